@@ src/fpa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the Q-format arithmetic unit
// Operation codes, entry format between front and back, divider step.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int WORD_W      = 16;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int FUNC_W      = 3;
    localparam int FRAC_W      = 4;
    localparam logic [FRAC_W-1:0] FRAC_MIN   = FRAC_W'(1);
    localparam logic [FRAC_W-1:0] FRAC_MAX   = FRAC_W'(WORD_W - 2);
    localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(8);

    // dividend magnitude is |a| shifted left by at most WORD_W-2
    localparam int NUM_W       = 2 * WORD_W - 2;
    localparam int REM_W       = WORD_W + 1;
    localparam int DIV_STEPS   = 2;
    localparam int DIV_STAGES  = NUM_W / DIV_STEPS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD,
        FUNC_SUB,
        FUNC_MUL,
        FUNC_DIV,
        FUNC_RND,
        FUNC_FROM_INT
    } func_t;

    // work left for the back end
    typedef enum logic [1:0] {
        CLS_DONE,
        CLS_MUL,
        CLS_DIV
    } cls_t;

    typedef struct packed {
        cls_t              cls;
        logic [FRAC_W-1:0] frac;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] res;
        logic              dz;
    } op_entry_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] nq;   // dividend bits shift out on top, quotient bits in below
    } div_work_t;

    typedef struct packed {
        cls_t              cls;
        logic [FRAC_W-1:0] frac;
        logic              neg;
        logic [WORD_W-1:0] den;
        div_work_t         work;
        logic [WORD_W-1:0] res;
        logic              dz;
    } stage_t;

    // one restoring division step
    function automatic div_work_t div_step(div_work_t w, logic [WORD_W-1:0] den);
        logic [REM_W-1:0] sh;
        div_work_t        o;
        sh = {w.rem[REM_W-2:0], w.nq[NUM_W-1]};
        if (sh >= {1'b0, den}) begin
            o.rem = sh - {1'b0, den};
            o.nq  = {w.nq[NUM_W-2:0], 1'b1};
        end else begin
            o.rem = sh;
            o.nq  = {w.nq[NUM_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage
`default_nettype wire

@@ src/fpa_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_front: operation intake and classification
// Holds the fraction count, takes transactions, finishes the simple
// operations and tags multiply and divide for the back end.
// ----------------------------------------------------------------------------
module fpa_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [fpa_pkg::FRAC_W-1:0]          cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [fpa_pkg::FUNC_W-1:0]          s_func,
    input  wire logic signed [fpa_pkg::WORD_W-1:0]   s_operand_a,
    input  wire logic signed [fpa_pkg::WORD_W-1:0]   s_operand_b,
    output logic                                     ent_valid,
    input  wire logic                                ent_ready,
    output fpa_pkg::op_entry_t                       ent
);

    logic [fpa_pkg::FRAC_W-1:0] frac_reg;
    logic [fpa_pkg::FRAC_W-1:0] eff_frac;
    logic                       vld_reg;
    logic                       vld_next;
    fpa_pkg::op_entry_t         ent_reg;
    fpa_pkg::op_entry_t         ent_next;
    logic signed [fpa_pkg::WORD_W-1:0] a_shr;
    logic                       half;
    logic                       s_fire;

    always_comb begin
        eff_frac = frac_reg;
        if (frac_reg < fpa_pkg::FRAC_MIN) begin
            eff_frac = fpa_pkg::FRAC_MIN;
        end else if (frac_reg > fpa_pkg::FRAC_MAX) begin
            eff_frac = fpa_pkg::FRAC_MAX;
        end
    end

    assign s_ready = !vld_reg || ent_ready;
    assign s_fire  = s_valid && s_ready;

    // round half up: floor(a / 2^f) plus the first dropped bit
    assign a_shr = s_operand_a >>> eff_frac;
    assign half  = s_operand_a[eff_frac - fpa_pkg::FRAC_W'(1)];

    always_comb begin
        ent_next.cls  = fpa_pkg::CLS_DONE;
        ent_next.frac = eff_frac;
        ent_next.a    = s_operand_a;
        ent_next.b    = s_operand_b;
        ent_next.res  = '0;
        ent_next.dz   = 1'b0;
        case (fpa_pkg::func_t'(s_func))
            fpa_pkg::FUNC_ADD: begin
                ent_next.res = s_operand_a + s_operand_b;
            end
            fpa_pkg::FUNC_SUB: begin
                ent_next.res = s_operand_a - s_operand_b;
            end
            fpa_pkg::FUNC_MUL: begin
                ent_next.cls = fpa_pkg::CLS_MUL;
            end
            fpa_pkg::FUNC_DIV: begin
                if (s_operand_b == '0) begin
                    ent_next.dz = 1'b1;
                end else begin
                    ent_next.cls = fpa_pkg::CLS_DIV;
                end
            end
            fpa_pkg::FUNC_RND: begin
                ent_next.res = a_shr + fpa_pkg::WORD_W'(half);
            end
            fpa_pkg::FUNC_FROM_INT: begin
                ent_next.res = s_operand_a << eff_frac;
            end
            default: begin
                ent_next.res = '0;
            end
        endcase
    end

    always_comb begin
        vld_next = vld_reg;
        if (s_fire) begin
            vld_next = 1'b1;
        end else if (ent_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_reg <= fpa_pkg::FRAC_RESET;
            vld_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                frac_reg <= cfg_wdata;
            end
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ent_reg <= ent_next;
        end
    end

    assign ent_valid = vld_reg;
    assign ent       = ent_reg;

    a_dz_done : assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg && ent_reg.dz |-> ent_reg.cls == fpa_pkg::CLS_DONE && ent_reg.res == '0)
        else $error("zero divisor entry carries work or a nonzero result");

endmodule
`default_nettype wire

@@ src/fpa_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_queue: decoupling queue between front and back
// Small first-in first-out buffer of classified entries.
// ----------------------------------------------------------------------------
module fpa_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire fpa_pkg::op_entry_t push_entry,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output fpa_pkg::op_entry_t      pop_entry
);

    fpa_pkg::op_entry_t           mem_reg [fpa_pkg::QUEUE_DEPTH];
    logic [fpa_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [fpa_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [fpa_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [fpa_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [fpa_pkg::QCNT_W-1:0]   cnt_reg;
    logic [fpa_pkg::QCNT_W-1:0]   cnt_next;
    logic                         push;
    logic                         pop;

    localparam logic [fpa_pkg::QPTR_W-1:0] PTR_LAST = fpa_pkg::QPTR_W'(fpa_pkg::QUEUE_DEPTH - 1);
    localparam logic [fpa_pkg::QCNT_W-1:0] CNT_FULL = fpa_pkg::QCNT_W'(fpa_pkg::QUEUE_DEPTH);

    assign push_ready = cnt_reg != CNT_FULL;
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_cnt_range : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("queue fill count out of range");

    a_cnt_grow : assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue fill count did not follow a push");

endmodule
`default_nettype wire

@@ src/fpa_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_back: execution pipeline
// Operand prep and multiply, pipelined restoring divider, sign fix-up and
// output register. Simple results ride along to keep order.
// ----------------------------------------------------------------------------
module fpa_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire fpa_pkg::op_entry_t                in_entry,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [fpa_pkg::WORD_W-1:0]      m_result,
    output logic                                   m_div_by_zero
);

    localparam int LAST = fpa_pkg::DIV_STAGES;

    fpa_pkg::stage_t                    stg_reg [LAST + 1];
    fpa_pkg::stage_t                    stg0_next;
    logic [LAST:0]                      vld_reg;
    logic                               out_vld_reg;
    logic [fpa_pkg::WORD_W-1:0]         out_res_reg;
    logic [fpa_pkg::WORD_W-1:0]         out_res_next;
    logic                               out_dz_reg;
    logic signed [fpa_pkg::PROD_W-1:0]  prod_reg;
    logic signed [fpa_pkg::PROD_W-1:0]  prod_next;
    logic signed [fpa_pkg::PROD_W-1:0]  prod_shr;
    logic [fpa_pkg::WORD_W-1:0]         mul_res;
    logic [fpa_pkg::WORD_W-1:0]         a_mag;
    logic [fpa_pkg::WORD_W-1:0]         b_mag;
    logic [fpa_pkg::WORD_W-1:0]         quo;
    logic                               adv;

    // the whole pipeline moves unless a finished result is held
    assign adv      = !out_vld_reg || m_ready;
    assign in_ready = adv;

    // stage 0: magnitudes, shifted dividend, full product
    assign a_mag     = in_entry.a[fpa_pkg::WORD_W-1] ? -in_entry.a : in_entry.a;
    assign b_mag     = in_entry.b[fpa_pkg::WORD_W-1] ? -in_entry.b : in_entry.b;
    assign prod_next = $signed(in_entry.a) * $signed(in_entry.b);

    always_comb begin
        stg0_next.cls      = in_entry.cls;
        stg0_next.frac     = in_entry.frac;
        stg0_next.neg      = in_entry.a[fpa_pkg::WORD_W-1] ^ in_entry.b[fpa_pkg::WORD_W-1];
        stg0_next.den      = b_mag;
        stg0_next.work.rem = '0;
        stg0_next.work.nq  = fpa_pkg::NUM_W'(a_mag) << in_entry.frac;
        stg0_next.res      = in_entry.res;
        stg0_next.dz       = in_entry.dz;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stg_reg[0] <= stg0_next;
            prod_reg   <= prod_next;
        end
    end

    assign prod_shr = prod_reg >>> stg_reg[0].frac;
    assign mul_res  = prod_shr[fpa_pkg::WORD_W-1:0];

    // divider stages, two quotient bits each; the first also scales the product
    for (genvar k = 1; k <= LAST; k++) begin : g_div
        fpa_pkg::stage_t stage_next;

        always_comb begin
            stage_next = stg_reg[k-1];
            for (int i = 0; i < fpa_pkg::DIV_STEPS; i++) begin
                stage_next.work = fpa_pkg::div_step(stage_next.work, stage_next.den);
            end
            if (k == 1 && stg_reg[k-1].cls == fpa_pkg::CLS_MUL) begin
                stage_next.res = mul_res;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                stg_reg[k] <= stage_next;
            end
        end
    end

    // only the low word of the quotient survives the wrap
    assign quo = stg_reg[LAST].work.nq[fpa_pkg::WORD_W-1:0];

    always_comb begin
        out_res_next = stg_reg[LAST].res;
        if (stg_reg[LAST].cls == fpa_pkg::CLS_DIV) begin
            out_res_next = stg_reg[LAST].neg ? -quo : quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[LAST-1:0], in_valid};
            out_vld_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_res_reg <= out_res_next;
            out_dz_reg  <= stg_reg[LAST].dz;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_result      = out_res_reg;
    assign m_div_by_zero = out_dz_reg;

    a_dz_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_dz_reg |-> out_res_reg == '0)
        else $error("zero divisor result is not zero");

    a_pipe_move : assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> out_vld_reg == $past(vld_reg[LAST]))
        else $error("output valid lost or invented on advance");

endmodule
`default_nettype wire

@@ src/fixed_point_alu_q16.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu_q16: 16-bit signed Q-format arithmetic unit
// Add, subtract, multiply, divide, round to integer and convert from
// integer with a configurable fraction count; all results wrap.
// ----------------------------------------------------------------------------
//  channel  | ports                                      | direction
//  ---------+--------------------------------------------+----------
//  input    | s_valid s_ready s_func s_operand_a/b       | in
//  result   | m_valid m_ready m_result m_div_by_zero     | out
//  config   | cfg_we cfg_wdata (fraction count)          | in
//
// one transaction per cycle sustained while m_ready is high, in any mix of operations
// results pass through the front register, queue, operand prep, 15 divider
// stages of two quotient bits each, and the output register
// every operation runs the full divider pipeline so results leave in order
// a held result stalls the back end; the queue lets the front keep taking
// no clearing pass after reset; fraction count resets to 8
// ----------------------------------------------------------------------------
module fixed_point_alu_q16 (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [fpa_pkg::FRAC_W-1:0]         cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [fpa_pkg::FUNC_W-1:0]         s_func,
    input  wire logic signed [fpa_pkg::WORD_W-1:0]  s_operand_a,
    input  wire logic signed [fpa_pkg::WORD_W-1:0]  s_operand_b,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [fpa_pkg::WORD_W-1:0]       m_result,
    output logic                                    m_div_by_zero
);

    logic               fq_valid;
    logic               fq_ready;
    fpa_pkg::op_entry_t fq_entry;
    logic               qb_valid;
    logic               qb_ready;
    fpa_pkg::op_entry_t qb_entry;

    fpa_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .ent_valid   (fq_valid),
        .ent_ready   (fq_ready),
        .ent         (fq_entry)
    );

    fpa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_entry (fq_entry),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_entry  (qb_entry)
    );

    fpa_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (qb_valid),
        .in_ready      (qb_ready),
        .in_entry      (qb_entry),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result      (m_result),
        .m_div_by_zero (m_div_by_zero)
    );

endmodule
`default_nettype wire
